// File: sv/desk_height_link_controller_assert.svh
`ifndef DESK_HEIGHT_LINK_CONTROLLER_ASSERT_SVH
`define DESK_HEIGHT_LINK_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define DHL_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DHL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/dhl_pkg.sv
package dhl_pkg;

  localparam int FRAME_LEN = 6;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int CMD_LEN   = 5;
  localparam int STEP_W    = $clog2(2 * CMD_LEN);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] HDR_IN       = 8'h98;
  localparam logic [7:0] HDR_CMD      = 8'hD8;
  localparam logic [7:0] CMD_ID       = 8'h66;
  localparam logic [7:0] RELEASE_CODE = 8'h00;

  localparam logic [2:0] FUNC_DESK    = 3'd0;
  localparam logic [2:0] FUNC_REMOTE  = 3'd1;
  localparam logic [2:0] FUNC_TICK    = 3'd2;
  localparam logic [2:0] FUNC_GOTO    = 3'd3;
  localparam logic [2:0] FUNC_UP_BY   = 3'd4;
  localparam logic [2:0] FUNC_DOWN_BY = 3'd5;
  localparam logic [2:0] FUNC_BUTTON  = 3'd6;

  localparam logic [2:0] CFG_RAW_MIN   = 3'd0;
  localparam logic [2:0] CFG_RAW_MAX   = 3'd1;
  localparam logic [2:0] CFG_BASE      = 3'd2;
  localparam logic [2:0] CFG_STEP      = 3'd3;
  localparam logic [2:0] CFG_TOLERANCE = 3'd4;
  localparam logic [2:0] CFG_UP_MASK   = 3'd5;
  localparam logic [2:0] CFG_DOWN_MASK = 3'd6;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_STATUS,
    KIND_FRAME,
    KIND_FRAME2
  } kind_e;

  // one queued job: everything the back end needs to emit a whole run
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        remote;
    logic        hnew;
    logic [15:0] height;
    logic        moving;
  } job_t;

endpackage

// File: sv/dhl_front.sv
module dhl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             accept_i,
  input  logic [2:0]       func_i,
  input  logic [7:0]       byte_value_i,
  input  logic [15:0]      amount_i,
  output dhl_pkg::job_t    job_o
);
  import dhl_pkg::*;

  logic [7:0]  raw_min_q, raw_max_q, up_mask_q, down_mask_q;
  logic [15:0] base_q, step_q, tol_q;

  logic [7:0]       frame_q [FRAME_LEN];
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      height_q, height_d;
  logic             known_q, known_d;
  logic [15:0]      target_q, target_d;
  logic             move_q, move_d;

  logic [7:0]  raw_off;
  logic [23:0] prod;
  logic [24:0] sum;
  logic [15:0] dec_height;
  logic        frame_ok;
  logic [16:0] up_sum;
  logic [15:0] up_target, down_target, diff;
  logic        start;
  logic [15:0] start_target;

  assign raw_off = frame_q[4] - raw_min_q;
  assign prod    = {8'b0, step_q} * {16'b0, raw_off};
  assign sum     = {9'b0, base_q} + {1'b0, prod};
  assign dec_height = (sum[24:16] != 9'b0) ? 16'hFFFF : sum[15:0];

  // sixth byte must repeat the raw code in the fifth
  assign frame_ok = (pos_q == POS_W'(FRAME_LEN - 1)) && (frame_q[0] == HDR_IN) &&
                    (frame_q[1] == HDR_IN) && (frame_q[4] == byte_value_i) &&
                    (frame_q[4] >= raw_min_q) && (frame_q[4] <= raw_max_q);

  assign up_sum      = {1'b0, height_q} + {1'b0, amount_i};
  assign up_target   = up_sum[16] ? 16'hFFFF : up_sum[15:0];
  assign down_target = (amount_i >= height_q) ? 16'h0000 : height_q - amount_i;
  assign diff        = (height_q >= target_q) ? height_q - target_q : target_q - height_q;

  always_comb begin
    pos_d        = pos_q;
    height_d     = height_q;
    known_d      = known_q;
    target_d     = target_q;
    move_d       = move_q;
    start        = 1'b0;
    start_target = amount_i;
    job_o.kind   = KIND_STATUS;
    job_o.data   = 8'h00;
    job_o.remote = 1'b0;
    job_o.hnew   = 1'b0;
    case (func_i)
      FUNC_DESK: begin
        pos_d = (pos_q == POS_W'(FRAME_LEN - 1)) ? '0 : pos_q + 1'b1;
        job_o.kind   = KIND_BYTE;
        job_o.data   = byte_value_i;
        job_o.remote = 1'b1;
        if (frame_ok && (!known_q || dec_height != height_q)) begin
          height_d   = dec_height;
          known_d    = 1'b1;
          job_o.hnew = 1'b1;
        end
      end
      FUNC_REMOTE: begin
        if (!move_q) begin
          job_o.kind = KIND_BYTE;
          job_o.data = byte_value_i;
        end
      end
      FUNC_TICK: begin
        if (move_q) begin
          if (diff <= tol_q) begin
            move_d = 1'b0;
          end else begin
            job_o.kind = KIND_FRAME;
            job_o.data = (height_q < target_q) ? up_mask_q : down_mask_q;
          end
        end
      end
      FUNC_GOTO: begin
        start = 1'b1;
      end
      FUNC_UP_BY: begin
        start        = 1'b1;
        start_target = up_target;
      end
      FUNC_DOWN_BY: begin
        start        = 1'b1;
        start_target = down_target;
      end
      FUNC_BUTTON: begin
        job_o.kind = KIND_FRAME2;
        job_o.data = byte_value_i;
      end
      default: begin
      end
    endcase
    // moves are ignored until a height has been seen
    if (start && known_q) begin
      target_d   = start_target;
      move_d     = 1'b1;
      job_o.kind = KIND_FRAME;
      job_o.data = RELEASE_CODE;
    end
    job_o.height = height_d;
    job_o.moving = move_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_min_q   <= 8'd0;
      raw_max_q   <= 8'd255;
      base_q      <= 16'd0;
      step_q      <= 16'd26;
      tol_q       <= 16'd64;
      up_mask_q   <= 8'd0;
      down_mask_q <= 8'd0;
      pos_q       <= '0;
      height_q    <= 16'd0;
      known_q     <= 1'b0;
      target_q    <= 16'd0;
      move_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_RAW_MIN:   raw_min_q   <= cfg_data_i[7:0];
          CFG_RAW_MAX:   raw_max_q   <= cfg_data_i[7:0];
          CFG_BASE:      base_q      <= cfg_data_i;
          CFG_STEP:      step_q      <= cfg_data_i;
          CFG_TOLERANCE: tol_q       <= cfg_data_i;
          CFG_UP_MASK:   up_mask_q   <= cfg_data_i[7:0];
          CFG_DOWN_MASK: down_mask_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      if (accept_i) begin
        pos_q    <= pos_d;
        height_q <= height_d;
        known_q  <= known_d;
        target_q <= target_d;
        move_q   <= move_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && func_i == FUNC_DESK) begin
      frame_q[pos_q] <= byte_value_i;
    end
  end

endmodule

// File: sv/dhl_queue.sv
module dhl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dhl_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output dhl_pkg::job_t job_o
);
  import dhl_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// File: sv/dhl_back.sv
module dhl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  dhl_pkg::job_t job_i,
  output logic          pop_o,
  output logic          res_valid_o,
  input  logic          res_stall_i,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          to_remote_o,
  output logic          height_new_o,
  output logic [15:0]   height_value_o,
  output logic          moving_o,
  output logic          last_of_run_o
);
  import dhl_pkg::*;

  logic [STEP_W-1:0] step_q;
  logic              res_valid_q;
  logic              load, last;
  logic              second;
  logic [STEP_W-1:0] pos;
  logic [7:0]        code, frame_byte;
  logic              b_valid, b_remote, b_hnew;
  logic [7:0]        b_byte;

  assign load = job_valid_i && (!res_valid_q || !res_stall_i);

  // position inside the current five-byte command frame
  assign second = (step_q >= STEP_W'(CMD_LEN));
  assign pos    = second ? step_q - STEP_W'(CMD_LEN) : step_q;
  assign code   = (job_i.kind == KIND_FRAME2 && !second) ? RELEASE_CODE : job_i.data;

  always_comb begin
    if (pos < STEP_W'(2)) begin
      frame_byte = HDR_CMD;
    end else if (pos == STEP_W'(2)) begin
      frame_byte = CMD_ID;
    end else begin
      frame_byte = code;
    end
  end

  always_comb begin
    b_valid  = 1'b1;
    b_byte   = frame_byte;
    b_remote = 1'b0;
    b_hnew   = 1'b0;
    last     = 1'b1;
    unique case (job_i.kind)
      KIND_BYTE: begin
        b_byte   = job_i.data;
        b_remote = job_i.remote;
        b_hnew   = job_i.hnew;
      end
      KIND_STATUS: begin
        b_valid = 1'b0;
        b_byte  = 8'h00;
      end
      KIND_FRAME: begin
        last = (step_q == STEP_W'(CMD_LEN - 1));
      end
      KIND_FRAME2: begin
        last = (step_q == STEP_W'(2 * CMD_LEN - 1));
      end
    endcase
  end

  assign pop_o       = load && last;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (load) begin
        res_valid_q <= 1'b1;
        step_q      <= last ? '0 : step_q + 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_valid_o    <= b_valid;
      out_byte_o     <= b_byte;
      to_remote_o    <= b_remote;
      height_new_o   <= b_hnew;
      height_value_o <= job_i.height;
      moving_o       <= job_i.moving;
      last_of_run_o  <= last;
    end
  end

endmodule

// File: sv/desk_height_link_controller.sv
// an accepted item is written into the job queue, and the back end registers each of its results
// throughput: one item per cycle while the two-entry job queue has room
// each item emits 1, 5 or 10 results from the back-end byte sequencer, one per cycle
// while res_stall_i is low, so the number of results depends on the command
// reset: rst_ni is asynchronous active low; clears link state, the queue and result valid,
// and loads the register defaults; frame bytes and result data are not cleared
module desk_height_link_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  byte_value_i,
  input  logic [15:0] amount_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        to_remote_o,
  output logic        height_new_o,
  output logic [15:0] height_value_o,
  output logic        moving_o,
  output logic        last_of_run_o
);
  import dhl_pkg::*;

  job_t front_job, head_job;
  logic q_full, q_valid, q_pop, accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  dhl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .func_i       (func_i),
    .byte_value_i (byte_value_i),
    .amount_i     (amount_i),
    .job_o        (front_job)
  );

  dhl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .job_i   (front_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (head_job)
  );

  dhl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (head_job),
    .pop_o          (q_pop),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .to_remote_o    (to_remote_o),
    .height_new_o   (height_new_o),
    .height_value_o (height_value_o),
    .moving_o       (moving_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// File: sv/dhl_checker.sv
`include "desk_height_link_controller_assert.svh"

module dhl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic        out_valid_o,
  input logic [7:0]  out_byte_o,
  input logic        to_remote_o,
  input logic        height_new_o,
  input logic [15:0] height_value_o,
  input logic        moving_o,
  input logic        last_of_run_o
);

  `DHL_ASSERT_NEXT(a_stall_hold, res_valid_o && res_stall_i,
    res_valid_o && $stable(out_byte_o) && $stable(out_valid_o), "stalled result changed")

  `DHL_ASSERT_NOW(a_status_only, res_valid_o && !out_valid_o,
    out_byte_o == 8'h00 && !to_remote_o && !height_new_o && last_of_run_o,
    "status result is not a lone empty result")

  `DHL_ASSERT_NOW(a_hnew_desk, res_valid_o && height_new_o,
    out_valid_o && to_remote_o && last_of_run_o, "height report not on a forwarded desk byte")

  `DHL_ASSERT_NEXT(a_run_steady, res_valid_o && !res_stall_i && !last_of_run_o,
    res_valid_o && $stable(moving_o) && $stable(height_value_o),
    "run broken or status changed inside a run")

endmodule

bind desk_height_link_controller dhl_checker u_dhl_checker (.*);
